### sv/ple_pkg.sv
// Shared types and constants for the permutohedral lattice embedding block.
`timescale 1ns / 1ps
package ple_pkg;

  localparam int LAT_DIM = 3;
  localparam int NUM_VERTS = LAT_DIM + 1;
  localparam int FEATURE_FRAC_BITS_DEF = 12;

  localparam int FEAT_W = 24;
  localparam int SCALE_W = 19;
  localparam int PROD_W = FEAT_W + SCALE_W;
  localparam int ELEV_W = 48;
  localparam int KEY_W = 16;
  localparam int WGT_W = 16;
  localparam int WEIGHT_ONE = 32768;

  // Elevation scale factors, unsigned Q16 with a leading zero so they read as signed.
  localparam logic [LAT_DIM-1:0][SCALE_W-1:0] SCALE_Q16 = {
    19'd61788, 19'd87381, 19'd151349
  };

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [1:0] VERTEX_LAST = 2'd3;

  typedef struct packed {
    logic signed [FEAT_W-1:0] feature_x;
    logic signed [FEAT_W-1:0] feature_y;
    logic signed [FEAT_W-1:0] feature_z;
  } feat_t;

  typedef struct packed {
    logic [1:0]              vertex_index;
    logic signed [KEY_W-1:0] key_first;
    logic signed [KEY_W-1:0] key_second;
    logic signed [KEY_W-1:0] key_third;
    logic [WGT_W-1:0]        vertex_weight;
    logic                    last_vertex;
  } vert_t;

  typedef struct packed {
    logic [LAT_DIM-1:0][KEY_W-1:0]   key_base;
    logic [LAT_DIM-1:0][1:0]         rank;
    logic [NUM_VERTS-1:0][WGT_W-1:0] weight;
  } entry_t;

endpackage

### sv/ple_front.sv
// Front pipeline: accepts points, finds the enclosing simplex and its weights.
`timescale 1ns / 1ps
module ple_front #(
  parameter int FEATURE_FRAC_BITS = ple_pkg::FEATURE_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            feat_valid,
  output logic            feat_ready,
  input  ple_pkg::feat_t  feat,
  input  logic            credit_return,
  output logic            push,
  output ple_pkg::entry_t push_entry
);
  import ple_pkg::*;

  localparam int FB = FEATURE_FRAC_BITS;
  localparam int REM_W = FB + 18;
  localparam int RW = FB + 21;
  localparam int BW = FB + 24;
  localparam int OW = BW + 1;
  localparam int WSH = FB + 3;
  localparam int STAGES = 7;

  localparam logic [REM_W-1:0] HALF_REM = REM_W'(1) << (FB + 17);
  localparam logic signed [RW-1:0] FOUR_RES = RW'(1) << (FB + 18);
  localparam logic signed [BW-1:0] FOUR_B = BW'(1) << (FB + 18);
  localparam logic signed [OW-1:0] HALF_W = OW'(1) << (WSH - 1);
  localparam logic signed [OW-1:0] W_MAX = OW'(WEIGHT_ONE);

  localparam logic signed [1:0] CORR_UP = 2'sb01;
  localparam logic signed [1:0] CORR_DN1 = 2'sb11;
  localparam logic signed [1:0] CORR_DN2 = 2'sb10;

  logic [QCNT_W-1:0] used;
  logic [QCNT_W-1:0] used_next;
  logic              accept;
  logic [STAGES-1:0] stage_valid;

  logic signed [FEAT_W-1:0] f1 [LAT_DIM];
  logic signed [PROD_W-1:0] cf2 [LAT_DIM];
  logic signed [ELEV_W-1:0] ce [LAT_DIM];
  logic signed [ELEV_W-1:0] elev3 [NUM_VERTS];

  logic [REM_W-1:0]    rem [NUM_VERTS];
  logic                rnd_up [NUM_VERTS];
  logic [KEY_W-1:0]    grd_n [NUM_VERTS];
  logic signed [RW-1:0] res_n [NUM_VERTS];
  logic [KEY_W-1:0]    grd4 [NUM_VERTS];
  logic signed [RW-1:0] res4 [NUM_VERTS];

  logic [KEY_W-1:0]     gsum;
  logic signed [1:0]    corr;
  logic [1:0]           rank_n [NUM_VERTS];
  logic                 adj_dn [NUM_VERTS];
  logic                 adj_up [NUM_VERTS];
  logic [KEY_W-1:0]     grd5 [LAT_DIM];
  logic signed [RW-1:0] res5 [NUM_VERTS];
  logic [1:0]           rank5 [NUM_VERTS];

  logic signed [RW-1:0] bary_pos [NUM_VERTS];
  logic signed [RW-1:0] bary_neg [NUM_VERTS];
  logic signed [BW-1:0] bary_n [NUM_VERTS];
  logic signed [BW-1:0] bary6 [NUM_VERTS];
  logic [KEY_W-1:0]     grd6 [LAT_DIM];
  logic [1:0]           rank6 [LAT_DIM];

  logic signed [OW-1:0] wsum [NUM_VERTS];
  logic signed [OW-1:0] wq [NUM_VERTS];
  logic [WGT_W-1:0]     wgt_n [NUM_VERTS];
  entry_t               entry7;

  assign feat_ready = (used != QCNT_W'(QUEUE_DEPTH));
  assign accept = feat_valid && feat_ready;

  always_comb begin
    used_next = used;
    if (accept && !credit_return) begin
      used_next = used + 1'b1;
    end else if (!accept && credit_return) begin
      used_next = used - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      stage_valid <= '0;
    end else begin
      used <= used_next;
      stage_valid <= {stage_valid[STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1[0] <= feat.feature_x;
      f1[1] <= feat.feature_y;
      f1[2] <= feat.feature_z;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LAT_DIM; i++) begin
      cf2[i] <= f1[i] * $signed(SCALE_Q16[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < LAT_DIM; i++) begin
      ce[i] = ELEV_W'(cf2[i]);
    end
  end

  always_ff @(posedge clk) begin
    elev3[0] <= ce[0] + ce[1] + ce[2];
    elev3[1] <= ce[2] + ce[1] - ce[0];
    elev3[2] <= ce[2] - (ce[1] <<< 1);
    elev3[3] <= -(ce[2] + (ce[2] <<< 1));
  end

  // Round each coordinate to a multiple of four lattice units, halfway going down.
  always_comb begin
    for (int i = 0; i < NUM_VERTS; i++) begin
      rem[i] = elev3[i][REM_W-1:0];
      rnd_up[i] = (rem[i] > HALF_REM);
      grd_n[i] = {elev3[i][FB+18 +: KEY_W-2], 2'b00} + (rnd_up[i] ? KEY_W'(4) : KEY_W'(0));
      res_n[i] = $signed({3'b000, rem[i]}) - (rnd_up[i] ? FOUR_RES : RW'(0));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_VERTS; i++) begin
      grd4[i] <= grd_n[i];
      res4[i] <= res_n[i];
    end
  end

  // The true coordinate sum is small, so its wrapped low bits carry the correction.
  always_comb begin
    gsum = grd4[0] + grd4[1] + grd4[2] + grd4[3];
    corr = $signed(gsum[3:2]);
    for (int k = 0; k < NUM_VERTS; k++) begin
      rank_n[k] = '0;
    end
    for (int i = 0; i < LAT_DIM; i++) begin
      for (int j = i + 1; j < NUM_VERTS; j++) begin
        if (res4[i] < res4[j]) begin
          rank_n[i] = rank_n[i] + 2'd1;
        end else begin
          rank_n[j] = rank_n[j] + 2'd1;
        end
      end
    end
    for (int k = 0; k < NUM_VERTS; k++) begin
      adj_dn[k] = (corr == CORR_UP) && (rank_n[k] == 2'd3);
      adj_up[k] = ((corr == CORR_DN1) && (rank_n[k] == 2'd0)) ||
                  ((corr == CORR_DN2) && (rank_n[k] < 2'd2));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_VERTS; k++) begin
      if (adj_dn[k]) begin
        res5[k] <= res4[k] + FOUR_RES;
      end else if (adj_up[k]) begin
        res5[k] <= res4[k] - FOUR_RES;
      end else begin
        res5[k] <= res4[k];
      end
      rank5[k] <= rank_n[k] + $unsigned(corr);
    end
    for (int k = 0; k < LAT_DIM; k++) begin
      if (adj_dn[k]) begin
        grd5[k] <= grd4[k] - KEY_W'(4);
      end else if (adj_up[k]) begin
        grd5[k] <= grd4[k] + KEY_W'(4);
      end else begin
        grd5[k] <= grd4[k];
      end
    end
  end

  // Barycentric weights, four times scaled, gathered by remainder rank.
  // The ranks are distinct, so each vertex takes exactly one remainder and gives up one.
  always_comb begin
    for (int c = 0; c < NUM_VERTS; c++) begin
      bary_pos[c] = '0;
      bary_neg[c] = '0;
      for (int i = 0; i < NUM_VERTS; i++) begin
        if (rank5[i] == 2'(3 - c)) begin
          bary_pos[c] = res5[i];
        end
        if (rank5[i] == 2'(4 - c)) begin
          bary_neg[c] = res5[i];
        end
      end
      bary_n[c] = ((c == 0) ? FOUR_B : BW'(0)) + BW'(bary_pos[c]) - BW'(bary_neg[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_VERTS; c++) begin
      bary6[c] <= bary_n[c];
    end
    for (int k = 0; k < LAT_DIM; k++) begin
      grd6[k] <= grd5[k];
      rank6[k] <= rank5[k];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_VERTS; c++) begin
      wsum[c] = OW'(bary6[c]) + HALF_W;
      wq[c] = wsum[c] >>> WSH;
      if (bary6[c] <= BW'(0)) begin
        wgt_n[c] = '0;
      end else if (wq[c] > W_MAX) begin
        wgt_n[c] = WGT_W'(WEIGHT_ONE);
      end else begin
        wgt_n[c] = wq[c][WGT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_VERTS; c++) begin
      entry7.weight[c] <= wgt_n[c];
    end
    for (int k = 0; k < LAT_DIM; k++) begin
      entry7.key_base[k] <= grd6[k];
      entry7.rank[k] <= rank6[k];
    end
  end

  assign push = stage_valid[STAGES-1];
  assign push_entry = entry7;

`ifndef SYNTH
  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used <= QCNT_W'(QUEUE_DEPTH))
    else $error("credit count above queue depth");
  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    push |-> used != '0)
    else $error("simplex pushed without a held credit");
`endif

endmodule

### sv/ple_queue.sv
// Short queue of finished simplex descriptions between front and back.
`timescale 1ns / 1ps
module ple_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ple_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            head_valid,
  output ple_pkg::entry_t head
);
  import ple_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head_valid = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");
`endif

endmodule

### sv/ple_back.sv
// Back sequencer: emits the four vertex beats of each queued simplex.
`timescale 1ns / 1ps
module ple_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  ple_pkg::entry_t head,
  output logic            pop,
  output logic            vert_valid,
  input  logic            vert_ready,
  output ple_pkg::vert_t  vert
);
  import ple_pkg::*;

  logic [1:0]       cnt;
  logic             load;
  logic [KEY_W-1:0] key_n [LAT_DIM];
  vert_t            vert_n;

  assign load = head_valid && (!vert_valid || vert_ready);
  assign pop = load && (cnt == VERTEX_LAST);

  // A key coordinate wraps by one period once its rank plus the vertex color exceeds three.
  always_comb begin
    for (int k = 0; k < LAT_DIM; k++) begin
      key_n[k] = head.key_base[k] + KEY_W'(cnt);
      if (({1'b0, head.rank[k]} + {1'b0, cnt}) > 3'd3) begin
        key_n[k] = key_n[k] - KEY_W'(4);
      end
    end
    vert_n.vertex_index = cnt;
    vert_n.key_first = $signed(key_n[0]);
    vert_n.key_second = $signed(key_n[1]);
    vert_n.key_third = $signed(key_n[2]);
    vert_n.vertex_weight = head.weight[cnt];
    vert_n.last_vertex = (cnt == VERTEX_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      vert_valid <= 1'b0;
    end else if (load) begin
      cnt <= cnt + 2'd1;
      vert_valid <= 1'b1;
    end else if (vert_ready) begin
      vert_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vert <= vert_n;
    end
  end

`ifndef SYNTH
  a_vertex_sequence: assert property (@(posedge clk) disable iff (rst)
    (vert_valid && vert_ready && !vert.last_vertex) |=>
      (vert_valid && (vert.vertex_index == $past(vert.vertex_index) + 2'd1)))
    else $error("vertex beats of one point not back to back in order");
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    vert_valid |-> vert.vertex_weight <= WGT_W'(WEIGHT_ONE))
    else $error("vertex weight above one");
`endif

endmodule

### sv/permutohedral_lattice_embed_core.sv
// Top level of the 3-D permutohedral lattice simplex embedding block.
//
// One beat on the feat channel carries a feature point (x, y, z). For each
// point the block sends four beats on the vert channel, vertex colors 0..3 in
// order, each with its lattice key, barycentric weight and a last flag set on
// color 3. Both channels use valid and ready.
// Each point passes the seven-stage front pipeline and the queue before its
// first vertex beat is registered; the other three follow on consecutive
// cycles while vert_ready is high. The single result register sends one
// vertex beat per cycle while vert_ready is high. The front pipeline takes a
// point in any cycle while a slot is free, so short bursts go in back to back.
// Up to 8 points are held between the front pipeline and the queue; feat_ready
// drops only when all 8 slots are taken.
// When the receiver stalls, the result register holds its beat, the queue
// fills, and then feat_ready falls until the receiver resumes.
// Reset clears the pipeline valids, the queue and the slot count; no vertex
// beat is valid after reset.
`timescale 1ns / 1ps
module permutohedral_lattice_embed_core #(
  parameter int FEATURE_FRAC_BITS = ple_pkg::FEATURE_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           feat_valid,
  output logic           feat_ready,
  input  ple_pkg::feat_t feat,
  output logic           vert_valid,
  input  logic           vert_ready,
  output ple_pkg::vert_t vert
);
  import ple_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  ple_front #(
    .FEATURE_FRAC_BITS(FEATURE_FRAC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .feat_valid(feat_valid),
    .feat_ready(feat_ready),
    .feat(feat),
    .credit_return(pop),
    .push(push),
    .push_entry(push_entry)
  );

  ple_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .head_valid(head_valid),
    .head(head)
  );

  ple_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head(head),
    .pop(pop),
    .vert_valid(vert_valid),
    .vert_ready(vert_ready),
    .vert(vert)
  );

endmodule

### sim/permutohedral_lattice_embed_check.sv
// Checker that predicts the four simplex vertex beats of each feature point and compares them.
`timescale 1ns / 1ps
module permutohedral_lattice_embed_check #(
  parameter int FEATURE_FRAC_BITS = ple_pkg::FEATURE_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           feat_valid,
  input  logic           feat_ready,
  input  ple_pkg::feat_t feat,
  input  logic           vert_valid,
  input  logic           vert_ready,
  input  ple_pkg::vert_t vert,
  output int             mismatches,
  output int             pending,
  output int             points_seen,
  output int             beats_seen
);
  import ple_pkg::*;

  localparam longint UNIT = longint'(1) << (FEATURE_FRAC_BITS + 16);
  localparam longint FOUR = 4 * UNIT;
  localparam longint SCALE_X = 151349;
  localparam longint SCALE_Y = 87381;
  localparam longint SCALE_Z = 61788;
  localparam longint Q15_ONE = 32768;
  localparam int MAX_PRINTED = 40;

  vert_t vertex_queue[$];
  vert_t want_beat;
  int fail_tally = 0;
  int point_tally = 0;
  int beat_tally = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_tally < MAX_PRINTED) begin
      $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    end
    fail_tally++;
  endtask

  function automatic logic [WGT_W-1:0] q15_weight(input longint four_bary);
    int sh;
    longint w;
    sh = FEATURE_FRAC_BITS + 3;
    if (four_bary <= 0) return '0;
    w = (four_bary + (longint'(1) << (sh - 1))) >>> sh;
    if (w > Q15_ONE) w = Q15_ONE;
    return w[WGT_W-1:0];
  endfunction

  function automatic void predict_simplex(input feat_t p);
    longint cf1, cf2, cf3, rem, pick, k, gsum;
    longint elev[NUM_VERTS];
    longint res[NUM_VERTS];
    longint grd[NUM_VERTS];
    longint bary[NUM_VERTS+1];
    logic [KEY_W-1:0] keys[LAT_DIM];
    int rnk[NUM_VERTS];
    int corr, r, i, j, c;
    vert_t v;

    cf1 = longint'(p.feature_x) * SCALE_X;
    cf2 = longint'(p.feature_y) * SCALE_Y;
    cf3 = longint'(p.feature_z) * SCALE_Z;
    elev[3] = -3 * cf3;
    elev[2] = cf3 - 2 * cf2;
    elev[1] = cf3 + cf2 - cf1;
    elev[0] = cf1 + cf2 + cf3;

    gsum = 0;
    for (i = 0; i < NUM_VERTS; i++) begin
      rem = elev[i] & (FOUR - 1);
      pick = elev[i] - rem;
      if (rem > 2 * UNIT) pick += FOUR;
      grd[i] = pick / UNIT;
      res[i] = elev[i] - pick;
      gsum += grd[i];
      rnk[i] = 0;
    end
    corr = int'(gsum / NUM_VERTS);

    for (i = 0; i < LAT_DIM; i++) begin
      for (j = i + 1; j < NUM_VERTS; j++) begin
        if (res[i] < res[j]) rnk[i]++;
        else rnk[j]++;
      end
    end

    if (corr > 0) begin
      for (i = 0; i < NUM_VERTS; i++) begin
        if (rnk[i] >= NUM_VERTS - corr) begin
          grd[i] -= NUM_VERTS;
          res[i] += FOUR;
          rnk[i] += corr - NUM_VERTS;
        end else begin
          rnk[i] += corr;
        end
      end
    end else if (corr < 0) begin
      for (i = 0; i < NUM_VERTS; i++) begin
        if (rnk[i] < -corr) begin
          grd[i] += NUM_VERTS;
          res[i] -= FOUR;
          rnk[i] += NUM_VERTS + corr;
        end else begin
          rnk[i] += corr;
        end
      end
    end

    for (i = 0; i <= NUM_VERTS; i++) bary[i] = 0;
    for (i = 0; i < NUM_VERTS; i++) begin
      r = rnk[i] & 3;
      bary[LAT_DIM - r] += res[i];
      bary[NUM_VERTS - r] -= res[i];
    end
    bary[0] += FOUR + bary[NUM_VERTS];

    for (c = 0; c < NUM_VERTS; c++) begin
      for (i = 0; i < LAT_DIM; i++) begin
        k = grd[i] + c;
        if (rnk[i] > LAT_DIM - c) k -= NUM_VERTS;
        keys[i] = k[KEY_W-1:0];
      end
      v.vertex_index = c[1:0];
      v.key_first = keys[0];
      v.key_second = keys[1];
      v.key_third = keys[2];
      v.vertex_weight = q15_weight(bary[c]);
      v.last_vertex = (c == NUM_VERTS - 1);
      vertex_queue.push_back(v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (feat_valid && feat_ready) begin
        predict_simplex(feat);
        point_tally++;
      end
      if (vert_valid && vert_ready) begin
        beat_tally++;
        if (vertex_queue.size() == 0) begin
          report_mismatch("vertex beat with no point outstanding, vertex_index",
                          vert.vertex_index, -1);
        end else begin
          want_beat = vertex_queue.pop_front();
          if (vert.vertex_index !== want_beat.vertex_index)
            report_mismatch("vertex_index", vert.vertex_index, want_beat.vertex_index);
          if (vert.key_first !== want_beat.key_first)
            report_mismatch("key_first", vert.key_first, want_beat.key_first);
          if (vert.key_second !== want_beat.key_second)
            report_mismatch("key_second", vert.key_second, want_beat.key_second);
          if (vert.key_third !== want_beat.key_third)
            report_mismatch("key_third", vert.key_third, want_beat.key_third);
          if (vert.vertex_weight !== want_beat.vertex_weight)
            report_mismatch("vertex_weight", vert.vertex_weight, want_beat.vertex_weight);
          if (vert.last_vertex !== want_beat.last_vertex)
            report_mismatch("last_vertex", vert.last_vertex, want_beat.last_vertex);
        end
      end
    end
    mismatches <= fail_tally;
    pending <= vertex_queue.size();
    points_seen <= point_tally;
    beats_seen <= beat_tally;
  end

endmodule

### sim/permutohedral_lattice_embed_core_test.sv
// Testbench top that drives feature points into the lattice embedding core and gives the verdict.
`timescale 1ns / 1ps
module permutohedral_lattice_embed_core_test;
  import ple_pkg::*;

  localparam int FRAC_BITS = FEATURE_FRAC_BITS_DEF;
  localparam longint FEAT_MAX = 8388607;
  localparam longint FEAT_MIN = -8388608;
  localparam longint HALF_STEP = longint'(1) << (FRAC_BITS + 17);
  localparam longint STEP_MOD = longint'(1) << (FRAC_BITS + 18);
  localparam int RANDOM_POINTS = 92;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic feat_valid = 1'b0;
  logic feat_ready;
  feat_t feat = '0;
  logic vert_valid;
  logic vert_ready = 1'b0;
  vert_t vert;

  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;
  int input_stalls = 0;
  int mismatches;
  int pending;
  int points_seen;
  int beats_seen;

  always #10 clk = ~clk;

  permutohedral_lattice_embed_core #(
    .FEATURE_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .feat_valid(feat_valid),
    .feat_ready(feat_ready),
    .feat      (feat),
    .vert_valid(vert_valid),
    .vert_ready(vert_ready),
    .vert      (vert)
  );

  permutohedral_lattice_embed_check #(
    .FEATURE_FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .feat_valid (feat_valid),
    .feat_ready (feat_ready),
    .feat       (feat),
    .vert_valid (vert_valid),
    .vert_ready (vert_ready),
    .vert       (vert),
    .mismatches (mismatches),
    .pending    (pending),
    .points_seen(points_seen),
    .beats_seen (beats_seen)
  );

  function automatic feat_t make_point(input longint x, input longint y, input longint z);
    feat_t p;
    p.feature_x = x[FEAT_W-1:0];
    p.feature_y = y[FEAT_W-1:0];
    p.feature_z = z[FEAT_W-1:0];
    return p;
  endfunction

  // A point whose first elevated coordinate lies exactly halfway between two multiples of four.
  function automatic feat_t halfway_point();
    longint a, b, inv, x, y;
    logic signed [FEAT_W-1:0] xr;
    a = 151349;
    b = 87381;
    inv = b;
    repeat (5) inv = inv * (2 - b * inv);
    do begin
      xr = FEAT_W'($urandom);
      x = xr;
      y = ((HALF_STEP - x * a) * inv) & (STEP_MOD - 1);
      if (y >= STEP_MOD / 2) y -= STEP_MOD;
    end while (y < FEAT_MIN || y > FEAT_MAX);
    return make_point(x, y, 0);
  endfunction

  function automatic feat_t random_point();
    int kind;
    logic signed [FEAT_W-1:0] fx, fy, fz, edge_val;
    kind = $urandom_range(99);
    fx = FEAT_W'($urandom);
    fy = FEAT_W'($urandom);
    fz = FEAT_W'($urandom);
    if (kind >= 30 && kind < 60) begin
      fx = FEAT_W'($urandom_range(0, 65535) - 32768);
      fy = FEAT_W'($urandom_range(0, 65535) - 32768);
      fz = FEAT_W'($urandom_range(0, 65535) - 32768);
    end else if (kind >= 60 && kind < 80) begin
      fx = FEAT_W'(($urandom_range(0, 127) - 64) << FRAC_BITS);
      fy = FEAT_W'(($urandom_range(0, 127) - 64) << FRAC_BITS);
      fz = FEAT_W'(($urandom_range(0, 127) - 64) << FRAC_BITS);
    end else if (kind >= 80 && kind < 94) begin
      edge_val = $urandom_range(1) ? FEAT_MAX[FEAT_W-1:0] : FEAT_MIN[FEAT_W-1:0];
      case ($urandom_range(2))
        0: fx = edge_val;
        1: fy = edge_val;
        default: fz = edge_val;
      endcase
    end else if (kind >= 94) begin
      return halfway_point();
    end
    return make_point(fx, fy, fz);
  endfunction

  task automatic send_point(input feat_t p);
    if (gaps_on) begin
      while ($urandom_range(99) < 14) begin
        feat_valid <= 1'b0;
        @(posedge clk);
      end
    end
    feat_valid <= 1'b1;
    feat <= p;
    @(posedge clk);
    while (!feat_ready) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        vert_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      vert_ready <= !(gaps_on && $urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    if (rst || (feat_valid && feat_ready) || (vert_valid && vert_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && feat_valid && !feat_ready) input_stalls <= input_stalls + 1;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_point(make_point(0, 0, 0));
    send_point(make_point(FEAT_MAX, 0, 0));
    send_point(make_point(FEAT_MIN, 0, 0));
    send_point(make_point(0, FEAT_MAX, 0));
    send_point(make_point(0, FEAT_MIN, 0));
    send_point(make_point(0, 0, FEAT_MAX));
    send_point(make_point(0, 0, FEAT_MIN));
    send_point(make_point(FEAT_MAX, FEAT_MAX, FEAT_MAX));
    send_point(make_point(FEAT_MIN, FEAT_MIN, FEAT_MIN));
    send_point(make_point(FEAT_MAX, FEAT_MIN, FEAT_MAX));
    send_point(make_point(FEAT_MIN, FEAT_MAX, FEAT_MIN));
    send_point(make_point(longint'(1) << FRAC_BITS, 0, 0));
    send_point(make_point(0, 0, longint'(3) << FRAC_BITS));
    send_point(make_point(-1, -1, -1));
    send_point(make_point(1, 1, 1));
    send_point(make_point(5, -7, 3));
    send_point(halfway_point());
    send_point(halfway_point());

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      if (n == 40) gaps_on <= 1'b0;
      if (n == 75) begin
        gaps_on <= 1'b1;
        hold_req <= 1'b1;
      end
      send_point(random_point());
    end
    feat_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d feature points and %0d vertex beats, with lattice points,",
             points_seen, beats_seen);
    $display("halfway rounding, tied remainders and %0d cycles of input back-pressure.",
             input_stalls);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### permutohedral_lattice_embed_core.f
sv/ple_pkg.sv
sv/ple_front.sv
sv/ple_queue.sv
sv/ple_back.sv
sv/permutohedral_lattice_embed_core.sv
sim/permutohedral_lattice_embed_check.sv
sim/permutohedral_lattice_embed_core_test.sv
